/* hw/rtl/eawd_pkg.sv */
// ----------------------------------------------------------------------------
// eawd_pkg
// Shared widths, constants and types for the encoder average and delta block.
// ----------------------------------------------------------------------------
package eawd_pkg;

  // field widths
  localparam int unsigned PosW  = 12;
  localparam int unsigned SumW  = 20;
  localparam int unsigned CntW  = 8;
  localparam int unsigned FineW = 19;

  // one count is 125/256 um, distance is kept in 1/256 um
  localparam int unsigned FineScale = 125;

  // reset value of the average count register
  localparam logic [CntW-1:0] AvgCountReset = CntW'(1);

  // configuration port decode
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = AddrW - 2;
  localparam logic [RegIdxW-1:0] RegAvgCount = RegIdxW'(0);

  // queue between accumulator and divider
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // finished accumulation handed to the back end
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [CntW-1:0] cnt;
  } acc_item_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* hw/rtl/eawd_front.sv */
// ----------------------------------------------------------------------------
// eawd_front
// Sample accumulator: sums samples and hands off a finished run to the queue.
// ----------------------------------------------------------------------------
module eawd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [eawd_pkg::CntW-1:0]   avg_count_i,
  input  logic                        sample_valid_i,
  output logic                        sample_ready_o,
  input  logic [eawd_pkg::PosW-1:0]   sample_i,
  input  eawd_pkg::fifo_stat_t        fifo_stat_i,
  output logic                        push_o,
  output eawd_pkg::acc_item_t         item_o
);

  logic [eawd_pkg::SumW-1:0] sum_q, sum_d, sum_add;
  logic [eawd_pkg::CntW-1:0] cnt_q, cnt_d, cnt_add;
  logic [eawd_pkg::CntW-1:0] target;
  logic                      accept;
  logic                      done;

  // a zero count behaves as one
  assign target = (avg_count_i == '0) ? eawd_pkg::CntW'(1) : avg_count_i;

  assign sample_ready_o = !fifo_stat_i.full;
  assign accept         = sample_valid_i && sample_ready_o;

  assign sum_add = sum_q + eawd_pkg::SumW'(sample_i);
  assign cnt_add = cnt_q + eawd_pkg::CntW'(1);
  assign done    = (cnt_add >= target);

  // hand off the finished run
  assign push_o     = accept && done;
  assign item_o.sum = sum_add;
  assign item_o.cnt = cnt_add;

  // accumulator update
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (done) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_add;
        cnt_d = cnt_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hw/rtl/eawd_fifo.sv */
// ----------------------------------------------------------------------------
// eawd_fifo
// Short queue of finished accumulations between front and back end.
// ----------------------------------------------------------------------------
module eawd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  eawd_pkg::acc_item_t   item_i,
  input  logic                  pop_i,
  output eawd_pkg::acc_item_t   item_o,
  output eawd_pkg::fifo_stat_t  stat_o
);

  eawd_pkg::acc_item_t                entry_q [eawd_pkg::FifoDepth];
  logic [eawd_pkg::FifoAw-1:0]        wr_ptr_q, wr_ptr_d;
  logic [eawd_pkg::FifoAw-1:0]        rd_ptr_q, rd_ptr_d;
  logic [eawd_pkg::FifoCntW-1:0]      count_q, count_d;
  logic                               do_push, do_pop;

  assign stat_o.full  = (count_q == eawd_pkg::FifoCntW'(eawd_pkg::FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign item_o       = entry_q[rd_ptr_q];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == eawd_pkg::FifoAw'(eawd_pkg::FifoDepth - 1)) ? '0
               : wr_ptr_q + eawd_pkg::FifoAw'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == eawd_pkg::FifoAw'(eawd_pkg::FifoDepth - 1)) ? '0
               : rd_ptr_q + eawd_pkg::FifoAw'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + eawd_pkg::FifoCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - eawd_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hw/rtl/eawd_back.sv */
// ----------------------------------------------------------------------------
// eawd_back
// Serial divider, wraparound delta and distance scaling with output register.
// ----------------------------------------------------------------------------
module eawd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  eawd_pkg::fifo_stat_t               fifo_stat_i,
  input  eawd_pkg::acc_item_t                item_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [eawd_pkg::PosW-1:0]          avg_o,
  output logic [eawd_pkg::PosW-1:0]          delta_o,
  output logic [eawd_pkg::FineW-1:0]         fine_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiv   = 2'd1;
  localparam logic [1:0] StDelta = 2'd2;
  localparam logic [1:0] StMul   = 2'd3;

  localparam int unsigned BitW = $clog2(eawd_pkg::PosW);

  logic [1:0]                    state_q, state_d;
  logic [eawd_pkg::CntW-1:0]     rem_q, rem_d;
  logic [eawd_pkg::PosW-1:0]     quo_q, quo_d;
  logic [eawd_pkg::CntW-1:0]     div_q, div_d;
  logic [BitW-1:0]               bit_q, bit_d;
  logic [eawd_pkg::PosW-1:0]     delta_q, delta_d;
  logic [eawd_pkg::PosW-1:0]     prev_q, prev_d;
  logic                          out_valid_q, out_valid_d;
  logic [eawd_pkg::PosW-1:0]     out_avg_q;
  logic [eawd_pkg::PosW-1:0]     out_delta_q;
  logic [eawd_pkg::FineW-1:0]    out_fine_q;

  logic [eawd_pkg::CntW:0]       trial;
  logic                          trial_ge;
  logic [eawd_pkg::CntW-1:0]     rem_next;
  logic signed [eawd_pkg::FineW-1:0] fine_prod;
  logic                          out_load;

  // one restoring division step, remainder stays below the divisor
  assign trial    = {rem_q, quo_q[eawd_pkg::PosW-1]};
  assign trial_ge = (trial >= {1'b0, div_q});
  assign rem_next = trial_ge ? eawd_pkg::CntW'(trial - {1'b0, div_q})
                             : trial[eawd_pkg::CntW-1:0];

  // distance scaling, delta is two's complement
  assign fine_prod = eawd_pkg::FineW'($signed(delta_q))
                   * $signed(eawd_pkg::FineW'(eawd_pkg::FineScale));

  assign pop_o    = (state_q == StIdle) && !fifo_stat_i.empty;
  assign out_load = (state_q == StMul) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    div_d   = div_q;
    bit_d   = bit_q;
    delta_d = delta_q;
    prev_d  = prev_q;
    unique case (state_q)
      StIdle: begin
        if (pop_o) begin
          // high sum bits are below the count since the mean fits 12 bits
          rem_d   = item_i.sum[eawd_pkg::SumW-1:eawd_pkg::PosW];
          quo_d   = item_i.sum[eawd_pkg::PosW-1:0];
          div_d   = item_i.cnt;
          bit_d   = BitW'(eawd_pkg::PosW - 1);
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d = rem_next;
        quo_d = {quo_q[eawd_pkg::PosW-2:0], trial_ge};
        bit_d = bit_q - BitW'(1);
        if (bit_q == '0) begin
          state_d = StDelta;
        end
      end
      StDelta: begin
        // modular difference read as signed gives the shortest path
        delta_d = quo_q - prev_q;
        prev_d  = quo_q;
        state_d = StMul;
      end
      StMul: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    div_q   <= div_d;
    bit_q   <= bit_d;
    delta_q <= delta_d;
    if (out_load) begin
      out_avg_q   <= quo_q;
      out_delta_q <= delta_q;
      out_fine_q  <= fine_prod;
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg_o       = out_avg_q;
  assign delta_o     = out_delta_q;
  assign fine_o      = out_fine_q;

endmodule

/* hw/rtl/encoder_average_and_wrap_delta_top.sv */
// ----------------------------------------------------------------------------
// encoder_average_and_wrap_delta_top
// Encoder position averager with shortest-path delta and fine distance.
// ----------------------------------------------------------------------------
// One 12-bit position sample is taken per cycle while the two-entry queue
// behind the accumulator has room. When average_count samples have been
// summed (a count of zero acts as one), the sum and count go to the back end,
// where a serial divider produces one quotient bit per cycle. For each result
// the back end loads the run, performs 12 divide steps, forms the wraparound
// delta and scales it by 125 into the output register, which it loads once
// that register is empty or being read. The back end takes no new run until
// the last result is in the output register, and once the queue fills it
// holds off the sample stream. The output register
// holds a finished result while the back end starts the next one.
module encoder_average_and_wrap_delta_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eawd_pkg::AddrW-1:0]    paddr,
  input  logic [eawd_pkg::DataW-1:0]    pwdata,
  output logic [eawd_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  // sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [11:0] position_sample
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata   // [11:0] average_position,
                                                       // [23:12] delta_counts,
                                                       // [42:24] distance_fine
);

  logic [eawd_pkg::CntW-1:0]   avg_count_q, avg_count_d;
  logic                        cfg_hit;
  eawd_pkg::fifo_stat_t        fifo_stat;
  eawd_pkg::acc_item_t         push_item, pop_item;
  logic                        push, pop;
  logic [eawd_pkg::PosW-1:0]   avg, delta;
  logic [eawd_pkg::FineW-1:0]  fine;

  // register access
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[eawd_pkg::AddrW-1:2] == eawd_pkg::RegAvgCount);
  assign prdata  = cfg_hit ? eawd_pkg::DataW'(avg_count_q) : '0;

  always_comb begin
    avg_count_d = avg_count_q;
    if (psel && penable && pwrite && pready && cfg_hit) begin
      avg_count_d = pwdata[eawd_pkg::CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_count_q <= eawd_pkg::AvgCountReset;
    end else begin
      avg_count_q <= avg_count_d;
    end
  end

  // accumulator
  eawd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avg_count_i    (avg_count_q),
    .sample_valid_i (s_axis_tvalid),
    .sample_ready_o (s_axis_tready),
    .sample_i       (s_axis_tdata[eawd_pkg::PosW-1:0]),
    .fifo_stat_i    (fifo_stat),
    .push_o         (push),
    .item_o         (push_item)
  );

  // queue between the two sides
  eawd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (pop_item),
    .stat_o (fifo_stat)
  );

  // divider and delta
  eawd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .item_i      (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .avg_o       (avg),
    .delta_o     (delta),
    .fine_o      (fine)
  );

  assign m_axis_tdata = {5'b0, fine, delta, avg};

endmodule

/* hw/rtl/eawd_checker.sv */
// ----------------------------------------------------------------------------
// eawd_checker
// Port-level checks for the encoder average and delta block.
// ----------------------------------------------------------------------------
module eawd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          pwrite,
  input  logic [eawd_pkg::DataW-1:0]    prdata,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [47:0]                   m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // distance is always the delta scaled by 125
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $signed(m_axis_tdata[42:24])
      == 19'($signed(m_axis_tdata[23:12]) * 19'sd125))
    else $error("distance does not match delta");

  // pad bits of the result stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:43] == 5'b0)
    else $error("result pad bits set");

  // register readback keeps the unused bits clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite |-> prdata[eawd_pkg::DataW-1:eawd_pkg::CntW] == '0)
    else $error("readback upper bits set");

endmodule

bind encoder_average_and_wrap_delta_top eawd_checker u_eawd_checker (.*);

/* verif/eawd_result_checker.sv */
// ----------------------------------------------------------------------------
// eawd_result_checker
// Watches the sample, result and configuration channels of the encoder
// averager, predicts every averaged result and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module eawd_result_checker
  import eawd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration port, observed only
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  input  logic [DataW-1:0] prdata_i,
  // sample stream
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [15:0]      s_tdata_i,   // [11:0] position_sample
  // result stream
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [47:0]      m_tdata_i,   // [11:0] average_position,
                                        // [23:12] delta_counts,
                                        // [42:24] distance_fine
  // status for the testbench top
  output int               pending_o,
  output int               mismatch_cnt_o
);

  localparam logic [AddrW-1:0] AvgCountAddr = AddrW'({RegAvgCount, 2'b00});
  localparam int unsigned      MaxReports   = 10;

  typedef struct packed {
    logic [PosW-1:0]         avg;
    logic signed [PosW-1:0]  delta;
    logic signed [FineW-1:0] fine;
  } enc_result_t;

  // averages predicted but not yet seen on the result stream
  enc_result_t pending_averages_q[$];

  // shadow of the block state
  logic [CntW-1:0] avg_count_q;
  logic [CntW-1:0] sample_cnt_q;
  logic [SumW-1:0] sample_sum_q;
  logic [PosW-1:0] prev_avg_q;
  int              mismatches;
  int              results_seen;

  // truncated mean, shortest wraparound step and distance in 1/256 um
  function automatic enc_result_t average_and_delta(input logic [SumW-1:0] sum,
                                                    input logic [CntW-1:0] cnt,
                                                    input logic [PosW-1:0] prev);
    enc_result_t             r;
    logic [PosW-1:0]         step;
    logic signed [FineW-1:0] step_ext;
    r.avg    = PosW'(sum / SumW'(cnt));
    step     = r.avg - prev;
    // reading the modular step as two's complement maps a half turn to -2048
    r.delta  = step;
    step_ext = FineW'(r.delta);
    r.fine   = FineW'(step_ext * FineW'(FineScale));
    return r;
  endfunction

  function automatic void note_mismatch(input string msg);
    if (mismatches < MaxReports) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
    mismatches++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_compare
    enc_result_t     want;
    enc_result_t     got;
    logic [SumW-1:0] sum_v;
    logic [CntW-1:0] cnt_v;
    logic [CntW-1:0] target_v;
    if (!rst_ni) begin
      avg_count_q  = AvgCountReset;
      sample_cnt_q = '0;
      sample_sum_q = '0;
      prev_avg_q   = '0;
      mismatches   = 0;
      results_seen = 0;
      pending_averages_q.delete();
    end else begin
      // register writes and read-back
      if (psel_i && penable_i && pready_i && paddr_i == AvgCountAddr) begin
        if (pwrite_i) begin
          avg_count_q = pwdata_i[CntW-1:0];
        end else if (prdata_i != DataW'(avg_count_q)) begin
          note_mismatch($sformatf("average_count read expected %0d got %0d",
                                  avg_count_q, prdata_i));
        end
      end

      // result transaction against the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got.avg   = m_tdata_i[PosW-1:0];
        got.delta = m_tdata_i[2*PosW-1:PosW];
        got.fine  = m_tdata_i[2*PosW+FineW-1:2*PosW];
        if (pending_averages_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result avg %0d delta %0d fine %0d",
                                  got.avg, $signed(got.delta), $signed(got.fine)));
        end else begin
          want = pending_averages_q.pop_front();
          if (got.avg != want.avg || got.delta != want.delta || got.fine != want.fine) begin
            note_mismatch($sformatf(
              "result %0d expected avg %0d delta %0d fine %0d, got avg %0d delta %0d fine %0d",
              results_seen, want.avg, $signed(want.delta), $signed(want.fine),
              got.avg, $signed(got.delta), $signed(got.fine)));
          end
        end
        results_seen++;
      end

      // sample transaction, a count of zero acts as one
      if (s_tvalid_i && s_tready_i) begin
        sum_v    = sample_sum_q + SumW'(s_tdata_i[PosW-1:0]);
        cnt_v    = sample_cnt_q + CntW'(1);
        target_v = (avg_count_q == '0) ? CntW'(1) : avg_count_q;
        if (cnt_v >= target_v) begin
          want = average_and_delta(sum_v, cnt_v, prev_avg_q);
          pending_averages_q.push_back(want);
          prev_avg_q   = want.avg;
          sample_sum_q = '0;
          sample_cnt_q = '0;
        end else begin
          sample_sum_q = sum_v;
          sample_cnt_q = cnt_v;
        end
      end
    end
    pending_o      <= pending_averages_q.size();
    mismatch_cnt_o <= mismatches;
  end

endmodule

/* verif/tb_encoder_average_and_wrap_delta_top.sv */
// ----------------------------------------------------------------------------
// tb_encoder_average_and_wrap_delta_top
// Stimulus and verdict for the encoder averager with wraparound delta.
// ----------------------------------------------------------------------------
// Directed samples cover position extremes, half-turn ties, the first result
// after reset, a zero average count and a count lowered mid-accumulation.
// Random phases then sweep the average count from 0 to 255 with random,
// corner and slowly moving samples, random gaps on both streams and one long
// result stall. eawd_result_checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_encoder_average_and_wrap_delta_top;
  import eawd_pkg::*;

  localparam logic [AddrW-1:0] AvgCountAddr  = AddrW'({RegAvgCount, 2'b00});
  localparam logic [AddrW-1:0] SpareAddr     = AddrW'({RegIdxW'(1), 2'b00});
  localparam logic [PosW-1:0]  PosMax        = '1;
  localparam logic [PosW-1:0]  PosHalf       = PosW'(1) << (PosW - 1);
  localparam int               TotalItems    = 1750;
  localparam int               DrainCycles   = 40;
  localparam int               HoldOffCycles = 400;
  localparam int               WatchdogLimit = 3000;
  localparam bit               CfgWrite      = 1'b1;
  localparam bit               CfgRead       = 1'b0;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata;   // [11:0] position_sample
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [47:0]      m_axis_tdata;   // [11:0] average_position,
                                    // [23:12] delta_counts,
                                    // [42:24] distance_fine
  int               pending;
  int               mismatch_cnt;
  int               sent_cnt;
  logic             hold_req;

  encoder_average_and_wrap_delta_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  eawd_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .pending_o      (pending),
    .mismatch_cnt_o (mismatch_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // corner positions, uniform positions, or a small move from the last one
  function automatic logic [PosW-1:0] next_sample(input logic [PosW-1:0] last);
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return PosMax;
          2:       return PosHalf;
          default: return PosHalf - PosW'(1);
        endcase
      end
      2, 3, 4, 5: return PosW'($urandom_range(0, PosMax));
      default:    return last + PosW'($urandom_range(0, 80) - 40);
    endcase
  endfunction

  // one configuration transaction, setup then access
  task automatic cfg_access(input bit wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [PosW-1:0] pos, input bit steady);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(16 - PosW){1'b0}}, pos};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // stop offering samples and let every predicted result drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // stimulus and verdict
  initial begin : stimulus
    logic [PosW-1:0] tie_walk[8];
    logic [PosW-1:0] partial[5];
    logic [PosW-1:0] last_smp;
    logic [PosW-1:0] smp;
    logic [CntW-1:0] avg_count;
    int              phase;
    int              n_items;
    bit              steady;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    sent_cnt      = 0;
    rst_ni        = 1'b0;
    tie_walk      = '{12'd0, 12'd2048, 12'd4095, 12'd0, 12'd4095, 12'd2047, 12'd0, 12'd1};
    partial       = '{12'd100, 12'd200, 12'd300, 12'd4000, 12'd4095};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset count of one: first delta against zero, half-turn ties, wrap both ways
    cfg_access(CfgRead, AvgCountAddr, '0);
    foreach (tie_walk[i]) send_sample(tie_walk[i], 1'b0);
    wait_idle();

    // zero count behaves as one, second sample is a tie from 3071 to 1023
    cfg_access(CfgWrite, AvgCountAddr, '0);
    send_sample(12'd3071, 1'b0);
    send_sample(12'd1023, 1'b0);
    wait_idle();

    // truncating division
    cfg_access(CfgWrite, AvgCountAddr, DataW'(3));
    send_sample(PosMax, 1'b0);
    send_sample(PosMax, 1'b0);
    send_sample(PosMax - PosW'(1), 1'b0);
    wait_idle();

    // writes beyond the register list leave the count alone
    cfg_access(CfgWrite, SpareAddr, DataW'(5));
    cfg_access(CfgRead, AvgCountAddr, '0);

    // count lowered while five samples are gathered, the sixth closes the average
    cfg_access(CfgWrite, AvgCountAddr, DataW'(8));
    foreach (partial[i]) send_sample(partial[i], 1'b0);
    wait_idle();
    cfg_access(CfgWrite, AvgCountAddr, DataW'(2));
    send_sample(12'd17, 1'b0);

    // random phases over the count range
    last_smp = 12'd17;
    phase    = 0;
    while (sent_cnt < TotalItems) begin
      wait_idle();
      case (phase)
        0: avg_count = '1;
        1: avg_count = CntW'(1);
        default: begin
          case ($urandom_range(0, 9))
            0:       avg_count = '0;
            1:       avg_count = '1;
            2:       avg_count = CntW'($urandom_range(16, 254));
            default: avg_count = CntW'($urandom_range(1, 8));
          endcase
        end
      endcase
      // upper write bits are junk, only the low byte is a register
      cfg_access(CfgWrite, AvgCountAddr, {(DataW - CntW)'($urandom()), avg_count});
      cfg_access(CfgRead, AvgCountAddr, '0);
      if (phase == 1) hold_req <= 1'b1;
      n_items = (avg_count > 60) ? 2 * avg_count + $urandom_range(0, 20)
                                 : $urandom_range(60, 150);
      steady  = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < n_items; k++) begin
        // the first full-count average is built from maximum positions
        smp = (phase == 0 && k < 255) ? PosMax : next_sample(last_smp);
        send_sample(smp, steady);
        last_smp = smp;
      end
      phase++;
    end

    wait_idle();
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result sink with random stalls and one long hold-off
  initial begin : result_sink
    int burst;
    int gap;
    bit hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                            : $urandom_range(1, 12);
        repeat (burst) @(posedge clk_i);
        gap = gap_len();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // watchdog on cycles without any stream transaction
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

endmodule
